// ===== src/bemseq_pkg.sv =====
// ----------------------------------------------------------------------------
// bemseq_pkg
// Types and constants shared by the bump escape motor sequencer files.
// ----------------------------------------------------------------------------
package bemseq_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_STEP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TICK_DIVIDE    = 2'd0,
    CFG_TURN_TICKS     = 2'd1,
    CFG_REPEAT_LIMIT   = 2'd2,
    CFG_REPEAT_TIMEOUT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MOT_FWD   = 3'd0,
    MOT_BACK  = 3'd1,
    MOT_LEFT  = 3'd2,
    MOT_RIGHT = 3'd3,
    MOT_NONE  = 3'd4
  } motion_t;

  // command codes
  localparam logic [7:0] CMD_FWD        = 8'h00;
  localparam logic [7:0] CMD_LEFT       = 8'h01;
  localparam logic [7:0] CMD_RIGHT      = 8'h02;
  localparam logic [7:0] CMD_REP_A      = 8'h10;
  localparam logic [7:0] CMD_BACK_LEFT  = 8'h11;
  localparam logic [7:0] CMD_REP_RIGHT  = 8'h20;
  localparam logic [7:0] CMD_BACK_RIGHT = 8'h22;
  localparam logic [7:0] CMD_REP_B      = 8'h30;

  // channel patterns, bit0 is channel five
  localparam logic [3:0] PAT_FWD   = 4'h6;
  localparam logic [3:0] PAT_BACK  = 4'h9;
  localparam logic [3:0] PAT_LEFT  = 4'h5;
  localparam logic [3:0] PAT_RIGHT = 4'hA;

  localparam logic [3:0] REPEAT_MAX = 4'hF;
  localparam logic [7:0] TURN_MAX   = 8'hFF;

  // reset values of the configuration registers
  localparam logic [15:0] RST_TICK_DIVIDE    = 16'd100;
  localparam logic [7:0]  RST_TURN_TICKS     = 8'd2;
  localparam logic [3:0]  RST_REPEAT_LIMIT   = 4'd3;
  localparam logic [7:0]  RST_REPEAT_TIMEOUT = 8'd10;

  typedef struct packed {
    logic [15:0] tick_divide;
    logic [7:0]  turn_ticks;
    logic [3:0]  repeat_limit;
    logic [7:0]  repeat_timeout;
  } bemseq_cfg_t;

  typedef struct packed {
    logic [7:0]  command;
    logic        turn_timing;
    logic [7:0]  turn_count;
    logic [3:0]  repeat_count;
    logic        repeat_armed;
    logic [7:0]  repeat_timer;
    logic [15:0] prescale_count;
    logic [3:0]  channel_state;
  } bemseq_state_t;

  typedef struct packed {
    logic [7:0] active_command;
    motion_t    motion;
    logic [3:0] channel_enables;
  } bemseq_result_t;

endpackage

// ===== src/bemseq_core.sv =====
// ----------------------------------------------------------------------------
// bemseq_core
// Next-state and result logic for one transfer: prescaler, control tick,
// command load and manager step.
// ----------------------------------------------------------------------------
module bemseq_core
  import bemseq_pkg::*;
(
  input  bemseq_cfg_t    cfg,
  input  bemseq_state_t  st,
  input  op_t            op,
  input  logic [7:0]     new_command,
  output bemseq_state_t  st_nxt,
  output bemseq_result_t res
);

  logic [16:0] pre_inc;
  logic [7:0]  timer_inc;
  logic        done;
  logic [3:0]  rep_upd;
  motion_t     mot;

  always_comb begin
    st_nxt    = st;
    mot       = MOT_NONE;
    pre_inc   = {1'b0, st.prescale_count} + 17'd1;
    timer_inc = st.repeat_timer + 8'd1;
    done      = (st.turn_count >= cfg.turn_ticks);
    rep_upd   = st.repeat_count;
    if (done && (st.repeat_count != REPEAT_MAX)) begin
      rep_upd = st.repeat_count + 4'd1;
    end

    unique case (op)
      OP_TICK: begin
        if (pre_inc > {1'b0, cfg.tick_divide}) begin
          st_nxt.prescale_count = '0;
          // turn counter saturates at its limit
          if (st.turn_timing && (st.turn_count < cfg.turn_ticks) &&
              (st.turn_count != TURN_MAX)) begin
            st_nxt.turn_count = st.turn_count + 8'd1;
          end
          if (st.repeat_armed) begin
            if (timer_inc >= cfg.repeat_timeout) begin
              st_nxt.repeat_armed = 1'b0;
              st_nxt.repeat_count = '0;
              st_nxt.repeat_timer = '0;
            end else begin
              st_nxt.repeat_timer = timer_inc;
            end
          end
        end else begin
          st_nxt.prescale_count = pre_inc[15:0];
        end
      end
      OP_LOAD: begin
        st_nxt.command = new_command;
      end
      OP_STEP: begin
        unique case (st.command)
          CMD_FWD: begin
            mot                  = MOT_FWD;
            st_nxt.channel_state = PAT_FWD;
          end
          CMD_LEFT, CMD_RIGHT: begin
            mot                  = (st.command == CMD_LEFT) ? MOT_LEFT : MOT_RIGHT;
            st_nxt.channel_state = (st.command == CMD_LEFT) ? PAT_LEFT : PAT_RIGHT;
            st_nxt.turn_timing   = ~done;
            if (done) begin
              st_nxt.turn_count = '0;
              st_nxt.command    = CMD_FWD;
            end
          end
          CMD_REP_A, CMD_REP_RIGHT, CMD_REP_B: begin
            mot                  = MOT_BACK;
            st_nxt.channel_state = PAT_BACK;
            st_nxt.turn_timing   = ~done;
            st_nxt.repeat_armed  = 1'b1;
            if (done) begin
              st_nxt.turn_count = '0;
            end
            // escape turn once enough back-ups in a row completed
            if (rep_upd >= cfg.repeat_limit) begin
              st_nxt.command      = (st.command == CMD_REP_RIGHT) ? CMD_RIGHT : CMD_LEFT;
              st_nxt.repeat_count = '0;
            end else begin
              st_nxt.repeat_count = rep_upd;
              if (done) begin
                st_nxt.command = CMD_FWD;
              end
            end
          end
          CMD_BACK_LEFT, CMD_BACK_RIGHT: begin
            mot                  = MOT_BACK;
            st_nxt.channel_state = PAT_BACK;
            st_nxt.turn_timing   = ~done;
            if (done) begin
              st_nxt.turn_count = '0;
              st_nxt.command    = (st.command == CMD_BACK_LEFT) ? CMD_LEFT : CMD_RIGHT;
            end
          end
          default: begin
            // unknown command falls back to forward; no motion is reported and the channel pattern holds
            st_nxt.command = CMD_FWD;
          end
        endcase
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase

    res.channel_enables = st_nxt.channel_state;
    res.motion          = mot;
    res.active_command  = st_nxt.command;
  end

endmodule

// ===== src/bump_escape_motor_sequencer.sv =====
// ----------------------------------------------------------------------------
// bump_escape_motor_sequencer
// Drive-direction sequencer for two DC motors on four H-bridge channels.
//
//   channel  dir  payload
//   in_      in   tuser[1:0] op, tdata[7:0] new_command
//   out_     out  tdata[3:0] channel_enables, [6:4] motion, [14:7] active_command
//   cfg_     in   wr_en, index[1:0], wdata[15:0]
//
// one transfer per cycle in while in_tready is high; each result is registered into the result buffer
// the state update is one combinational pass between the state and result registers
// a two-entry result buffer keeps the input taking transfers while out_ stalls
// in_tready drops only while both result entries are occupied
// rst_n is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module bump_escape_motor_sequencer
  import bemseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] new_command
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] channel_enables, [6:4] motion,
                                  // [14:7] active_command, [15] zero
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

  bemseq_cfg_t    cfg_r;
  bemseq_state_t  st_r;
  bemseq_state_t  st_nxt;
  bemseq_result_t res;
  bemseq_result_t slot0_r;
  bemseq_result_t slot1_r;
  logic [1:0]     count_r;
  logic           push;
  logic           pop;

  assign in_tready  = (count_r != BUF_FULL);
  assign out_tvalid = (count_r != BUF_EMPTY);
  assign push       = in_tvalid & in_tready;
  assign pop        = out_tvalid & out_tready;
  assign out_tdata  = {1'b0, slot0_r};

  bemseq_core u_core (
    .cfg         (cfg_r),
    .st          (st_r),
    .op          (op_t'(in_tuser)),
    .new_command (in_tdata),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_divide    <= RST_TICK_DIVIDE;
      cfg_r.turn_ticks     <= RST_TURN_TICKS;
      cfg_r.repeat_limit   <= RST_REPEAT_LIMIT;
      cfg_r.repeat_timeout <= RST_REPEAT_TIMEOUT;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TICK_DIVIDE:    cfg_r.tick_divide    <= cfg_wdata;
        CFG_TURN_TICKS:     cfg_r.turn_ticks     <= cfg_wdata[7:0];
        CFG_REPEAT_LIMIT:   cfg_r.repeat_limit   <= cfg_wdata[3:0];
        CFG_REPEAT_TIMEOUT: cfg_r.repeat_timeout <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (push) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= BUF_EMPTY;
    end else begin
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // result slots carry payload only
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count_r == BUF_EMPTY) begin
          slot0_r <= res;
        end else begin
          slot1_r <= res;
        end
      end
      2'b01: begin
        slot0_r <= slot1_r;
      end
      2'b11: begin
        if (count_r == BUF_ONE) begin
          slot0_r <= res;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/bemseq_checker.sv =====
// ----------------------------------------------------------------------------
// bemseq_checker
// Port-level checks for the bump escape motor sequencer, bound to the top.
// ----------------------------------------------------------------------------
module bemseq_checker
  import bemseq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input stalls only while results are pending
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // after every accepted input a result is pending on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after input transfer");

  // a driven motion carries its channel pattern
  a_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[6:4] == MOT_NONE) ||
      (out_tdata[6:4] == MOT_FWD   && out_tdata[3:0] == PAT_FWD) ||
      (out_tdata[6:4] == MOT_BACK  && out_tdata[3:0] == PAT_BACK) ||
      (out_tdata[6:4] == MOT_LEFT  && out_tdata[3:0] == PAT_LEFT) ||
      (out_tdata[6:4] == MOT_RIGHT && out_tdata[3:0] == PAT_RIGHT))
    else $error("motion and channel pattern disagree");

endmodule

bind bump_escape_motor_sequencer bemseq_checker u_bemseq_checker (.*);
